// ----- rtl/i8dps_pkg.sv -----
// Shared constants, types and command codes for the int8 dot-product scanner.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package i8dps_pkg;

  localparam int MAX_DIMENSIONS = 256;
  localparam int LANES          = 8;
  localparam int ELEM_W         = 8;
  localparam int DIM_W          = 9;
  localparam int ROW_W          = 24;
  localparam int ACC_W          = 24;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 24;

  localparam int CHUNKS_MAX = MAX_DIMENSIONS / LANES;
  localparam int CHUNK_W    = $clog2(CHUNKS_MAX);
  localparam int LANE_W     = $clog2(LANES);
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int SUM_W      = PROD_W + LANE_W;

  typedef enum logic {
    CMD_QUERY = 1'b0,
    CMD_ROW   = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIMENSIONS = 1'b0,
    REG_FIRST_ROW  = 1'b1
  } reg_idx_t;

  typedef logic [LANES-1:0][ELEM_W-1:0] chunk_t;

  // query store write: one chunk row, one byte enable per lane
  typedef struct packed {
    logic               we;
    logic [CHUNK_W-1:0] addr;
    logic [LANES-1:0]   be;
  } qwr_t;

  // row chunk control handed to the multiply/accumulate pipe at accept
  typedef struct packed {
    logic             take;
    logic [LANES-1:0] mask;
    logic             ends;
  } row_ctl_t;

endpackage

// ----- rtl/i8dps_qmem.sv -----
// Query store: one synchronous memory row per chunk, byte write enables per lane.
// Read data is registered. Depends on i8dps_pkg.
module i8dps_qmem (
  input  logic                    clk,
  input  i8dps_pkg::qwr_t         wr,
  input  i8dps_pkg::chunk_t       wr_data,
  input  logic                    rd_en,
  input  logic [i8dps_pkg::CHUNK_W-1:0] rd_addr,
  output i8dps_pkg::chunk_t       rd_data_r
);

  i8dps_pkg::chunk_t mem [i8dps_pkg::CHUNKS_MAX];

  always_ff @(posedge clk) begin
    for (int l = 0; l < i8dps_pkg::LANES; l++) begin
      if (wr.we && wr.be[l]) begin
        mem[wr.addr][l] <= wr_data[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/i8dps_seq.sv -----
// Chunk sequencer: query and row chunk positions, tail-lane masks and
// query store addressing. Depends on i8dps_pkg.
module i8dps_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  i8dps_pkg::cmd_t               cmd,
  input  logic [i8dps_pkg::DIM_W-1:0]   dims,
  output i8dps_pkg::qwr_t               qwr,
  output logic                          rd_en,
  output logic [i8dps_pkg::CHUNK_W-1:0] rd_addr,
  output i8dps_pkg::row_ctl_t           row_ctl
);

  logic [i8dps_pkg::DIM_W-1:0]   dim_eff;
  logic [i8dps_pkg::DIM_W-1:0]   dim_m1;
  logic [i8dps_pkg::CHUNK_W-1:0] last_chunk;
  logic [i8dps_pkg::CHUNK_W-1:0] qpos_r, qpos_nxt, qbase;
  logic [i8dps_pkg::CHUNK_W-1:0] rpos_r, rpos_nxt, rbase;
  logic                          q_take, r_take;

  // lanes whose element position lies below the dimension
  function automatic logic [i8dps_pkg::LANES-1:0] lane_mask(
    input logic [i8dps_pkg::CHUNK_W-1:0] base,
    input logic [i8dps_pkg::DIM_W-1:0]   d
  );
    logic [i8dps_pkg::LANES-1:0]                   m;
    logic [i8dps_pkg::CHUNK_W+i8dps_pkg::LANE_W-1:0] pos;
    for (int l = 0; l < i8dps_pkg::LANES; l++) begin
      pos  = {base, i8dps_pkg::LANE_W'(l)};
      m[l] = (i8dps_pkg::DIM_W'(pos) < d);
    end
    return m;
  endfunction

  always_comb begin
    if (dims == '0) begin
      dim_eff = i8dps_pkg::DIM_W'(1);
    end else if (dims > i8dps_pkg::DIM_W'(i8dps_pkg::MAX_DIMENSIONS)) begin
      dim_eff = i8dps_pkg::DIM_W'(i8dps_pkg::MAX_DIMENSIONS);
    end else begin
      dim_eff = dims;
    end
    dim_m1     = dim_eff - i8dps_pkg::DIM_W'(1);
    last_chunk = dim_m1[i8dps_pkg::LANE_W +: i8dps_pkg::CHUNK_W];

    // stale query position restarts; stale row position ends the row
    qbase = (qpos_r > last_chunk) ? '0 : qpos_r;
    rbase = (rpos_r > last_chunk) ? last_chunk : rpos_r;

    q_take = take && (cmd == i8dps_pkg::CMD_QUERY);
    r_take = take && (cmd == i8dps_pkg::CMD_ROW);

    qwr.we   = q_take;
    qwr.addr = qbase;
    qwr.be   = lane_mask(qbase, dim_eff);

    rd_en   = r_take;
    rd_addr = rbase;

    row_ctl.take = r_take;
    row_ctl.mask = lane_mask(rbase, dim_eff);
    row_ctl.ends = (rbase == last_chunk);

    qpos_nxt = qpos_r;
    if (q_take) begin
      qpos_nxt = (qbase == last_chunk) ? '0 : qbase + i8dps_pkg::CHUNK_W'(1);
    end
    rpos_nxt = rpos_r;
    if (r_take) begin
      rpos_nxt = row_ctl.ends ? '0 : rbase + i8dps_pkg::CHUNK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qpos_r <= '0;
      rpos_r <= '0;
    end else begin
      qpos_r <= qpos_nxt;
      rpos_r <= rpos_nxt;
    end
  end

endmodule

// ----- rtl/i8dps_mac.sv -----
// Multiply/accumulate pipe: lane products, then sum into the row accumulator,
// then the result register with row labelling. Depends on i8dps_pkg.
module i8dps_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  i8dps_pkg::row_ctl_t           row_ctl,
  input  i8dps_pkg::chunk_t             lanes,
  input  logic                          final_row,
  input  i8dps_pkg::chunk_t             qdata,
  input  logic [i8dps_pkg::ROW_W-1:0]   first_row,
  input  logic                          out_ready,
  output logic                          in_free,
  output logic                          out_valid,
  output logic signed [i8dps_pkg::ACC_W-1:0] out_score,
  output logic [i8dps_pkg::ROW_W-1:0]   out_row_id,
  output logic                          out_last
);

  // stage 1: chunk lanes, aligned with the query store read data
  logic                          s1_valid_r;
  i8dps_pkg::chunk_t             s1_lanes_r;
  logic [i8dps_pkg::LANES-1:0]   s1_mask_r;
  logic                          s1_ends_r;
  logic                          s1_final_r;

  // stage 2: lane products
  logic                          s2_valid_r;
  logic signed [i8dps_pkg::PROD_W-1:0] prod_r   [i8dps_pkg::LANES];
  logic signed [i8dps_pkg::PROD_W-1:0] prod_nxt [i8dps_pkg::LANES];
  logic                          s2_ends_r;
  logic                          s2_final_r;

  logic [i8dps_pkg::ACC_W-1:0]   acc_r;
  logic [i8dps_pkg::ROW_W-1:0]   rows_r;
  logic                          out_valid_r;
  logic [i8dps_pkg::ACC_W-1:0]   score_r;
  logic [i8dps_pkg::ROW_W-1:0]   row_id_r;
  logic                          last_r;

  logic signed [i8dps_pkg::SUM_W-1:0] sum;
  logic [i8dps_pkg::ACC_W-1:0]   acc_sum;
  logic                          out_free, s2_go, s2_free, s1_go;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    // a chunk that does not end its row needs no room in the result register
    s2_go    = s2_valid_r && (!s2_ends_r || out_free);
    s2_free  = !s2_valid_r || s2_go;
    s1_go    = s1_valid_r && s2_free;
    in_free  = !s1_valid_r || s1_go;

    for (int l = 0; l < i8dps_pkg::LANES; l++) begin
      if (s1_mask_r[l]) begin
        prod_nxt[l] = $signed(s1_lanes_r[l]) * $signed(qdata[l]);
      end else begin
        prod_nxt[l] = '0;
      end
    end

    sum = '0;
    for (int l = 0; l < i8dps_pkg::LANES; l++) begin
      sum = sum + prod_r[l];
    end
    acc_sum = acc_r + i8dps_pkg::ACC_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      rows_r      <= '0;
    end else begin
      if (in_free) begin
        s1_valid_r <= row_ctl.take;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s2_go) begin
        if (s2_ends_r) begin
          acc_r  <= '0;
          rows_r <= s2_final_r ? '0 : rows_r + i8dps_pkg::ROW_W'(1);
        end else begin
          acc_r <= acc_sum;
        end
      end
      if (s2_go && s2_ends_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && row_ctl.take) begin
      s1_lanes_r <= lanes;
      s1_mask_r  <= row_ctl.mask;
      s1_ends_r  <= row_ctl.ends;
      s1_final_r <= final_row;
    end
    if (s1_go) begin
      prod_r     <= prod_nxt;
      s2_ends_r  <= s1_ends_r;
      s2_final_r <= s1_final_r;
    end
    if (s2_go && s2_ends_r) begin
      score_r  <= acc_sum;
      row_id_r <= first_row + rows_r;
      last_r   <= s2_final_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_score  = $signed(score_r);
  assign out_row_id = row_id_r;
  assign out_last   = last_r;

endmodule

// ----- rtl/int8_dot_product_scan_top.sv -----
// int8 dot-product scanner, top level: configuration registers, handshake,
// sequencer, query store and multiply/accumulate pipe.
// Depends on i8dps_pkg, i8dps_seq, i8dps_qmem, i8dps_mac.
//
// Usage: write dimensions (index 0) and first_row (index 1) on the cfg_ port
// while the block is idle. Send the query as words with in_cmd = 0, eight
// elements each, in order; then send row words with in_cmd = 1. Lanes beyond
// the dimension in a tail chunk are ignored. After the last chunk of a row the
// block presents one result word: score, row_id (first_row plus rows scored
// since the last row flagged final, modulo 2^24) and last.
// Throughput: one word per cycle on the input, query or row alike, while
// in_ready is high. Result path: the accept edge of a row's last chunk reads the
// query store, then lane products are registered, then the sum is accumulated
// into the result register that drives out_valid.
// Stall: when out_ready is low the result holds; chunks that do not end a row
// keep accumulating, and in_ready drops once a row's last chunk and one more
// row chunk wait behind it.
// Reset (rst_n low at a clock edge): chunk positions, accumulator, row count
// and the pipe clear; dimensions returns to 256, first_row to 0. The query
// store is not cleared and must be loaded before rows are sent.
module int8_dot_product_scan_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cmd,
  input  logic signed [7:0]                    in_lane0,
  input  logic signed [7:0]                    in_lane1,
  input  logic signed [7:0]                    in_lane2,
  input  logic signed [7:0]                    in_lane3,
  input  logic signed [7:0]                    in_lane4,
  input  logic signed [7:0]                    in_lane5,
  input  logic signed [7:0]                    in_lane6,
  input  logic signed [7:0]                    in_lane7,
  input  logic                                 in_final_row,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [i8dps_pkg::ACC_W-1:0]   out_score,
  output logic [i8dps_pkg::ROW_W-1:0]          out_row_id,
  output logic                                 out_last,
  input  logic                                 cfg_we,
  input  logic [i8dps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [i8dps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [i8dps_pkg::DIM_W-1:0]   dims_r;
  logic [i8dps_pkg::ROW_W-1:0]   first_row_r;
  logic                          take;
  i8dps_pkg::cmd_t               cmd;
  i8dps_pkg::chunk_t             lanes;
  i8dps_pkg::chunk_t             qdata;
  i8dps_pkg::qwr_t               qwr;
  i8dps_pkg::row_ctl_t           row_ctl;
  logic                          rd_en;
  logic [i8dps_pkg::CHUNK_W-1:0] rd_addr;
  logic                          in_free;

  assign take     = in_valid && in_free;
  assign in_ready = in_free;
  assign cmd      = i8dps_pkg::cmd_t'(in_cmd);
  assign lanes    = {in_lane7, in_lane6, in_lane5, in_lane4,
                     in_lane3, in_lane2, in_lane1, in_lane0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r      <= i8dps_pkg::DIM_W'(i8dps_pkg::MAX_DIMENSIONS);
      first_row_r <= '0;
    end else if (cfg_we) begin
      case (i8dps_pkg::reg_idx_t'(cfg_index))
        i8dps_pkg::REG_DIMENSIONS: dims_r      <= cfg_wdata[i8dps_pkg::DIM_W-1:0];
        i8dps_pkg::REG_FIRST_ROW:  first_row_r <= cfg_wdata[i8dps_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  i8dps_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .cmd     (cmd),
    .dims    (dims_r),
    .qwr     (qwr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .row_ctl (row_ctl)
  );

  i8dps_qmem u_qmem (
    .clk       (clk),
    .wr        (qwr),
    .wr_data   (lanes),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (qdata)
  );

  i8dps_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .row_ctl    (row_ctl),
    .lanes      (lanes),
    .final_row  (in_final_row),
    .qdata      (qdata),
    .first_row  (first_row_r),
    .out_ready  (out_ready),
    .in_free    (in_free),
    .out_valid  (out_valid),
    .out_score  (out_score),
    .out_row_id (out_row_id),
    .out_last   (out_last)
  );

  // the store is never written and read in the same cycle
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    qwr.we |-> !rd_en)
    else $error("query store written and read in one cycle");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  // a word is only taken when ready was up
  a_take_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en || qwr.we) |-> (in_valid && in_ready))
    else $error("store access without an accepted word");

endmodule
